// ----- rtl/spsm_pkg.sv -----
// ----------------------------------------------------------------------------
// spsm_pkg: shared types and constants for the servo slot multiplexer
// Field widths, request and result payloads, register map codes and reset
// values used by the channel interfaces and the top level.
// ----------------------------------------------------------------------------
package spsm_pkg;

    // Slot and group layout of the servo outputs
    localparam int SLOT_COUNT  = 8;
    localparam int GROUP_COUNT = 2;

    // Request and result field widths
    localparam int OP_W    = 1;
    localparam int CH_W    = 4;
    localparam int US_W    = 12;
    localparam int PINS_W  = 16;
    localparam int SLOT_W  = 3;

    // Timing widths
    localparam int CNT_W   = 16;
    localparam int TICK_W  = 13;

    // APB port widths
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // Request operation codes
    localparam logic [OP_W-1:0] OP_TICK  = 1'b0;
    localparam logic [OP_W-1:0] OP_WRITE = 1'b1;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_SLOT_TICKS = 2'd0;
    localparam logic [1:0] REG_MIN_US     = 2'd1;
    localparam logic [1:0] REG_MAX_US     = 2'd2;

    // Reset values
    localparam logic [CNT_W-1:0]  RST_SLOT_TICKS = 16'd5000;
    localparam logic [US_W-1:0]   RST_MIN_US     = 12'd900;
    localparam logic [US_W-1:0]   RST_MAX_US     = 12'd2100;
    localparam logic [TICK_W-1:0] RST_WIDTH      = 13'd3000;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [CH_W-1:0] channel;
        logic [US_W-1:0] width_us;
    } t_req;

    typedef struct packed {
        logic [PINS_W-1:0] servo_pins;
        logic [SLOT_W-1:0] active_slot;
    } t_rsp;

endpackage

// ----- rtl/spsm_if.sv -----
// ----------------------------------------------------------------------------
// spsm_req_if / spsm_rsp_if: valid/ready channels of the slot multiplexer
// A request moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface spsm_req_if;
    logic                      valid;
    logic                      ready;
    logic [spsm_pkg::OP_W-1:0] op;
    logic [spsm_pkg::CH_W-1:0] channel;
    logic [spsm_pkg::US_W-1:0] width_us;

    modport source (output valid, op, channel, width_us, input ready);
    modport sink   (input valid, op, channel, width_us, output ready);
endinterface

interface spsm_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [spsm_pkg::PINS_W-1:0] servo_pins;
    logic [spsm_pkg::SLOT_W-1:0] active_slot;

    modport source (output valid, servo_pins, active_slot, input ready);
    modport sink   (input valid, servo_pins, active_slot, output ready);
endinterface

// ----- rtl/servo_pwm_slot_multiplexer.sv -----
// ----------------------------------------------------------------------------
// servo_pwm_slot_multiplexer: slot-multiplexed servo pulse generator
// Groups of servo outputs share one half-microsecond tick counter; each slot
// raises one pin per group and drops it when the count meets its width.
//
//   Channel   Direction  Handshake       Payload
//   i_req     in         valid / ready   op, channel, width_us
//   o_rsp     out        valid / ready   servo_pins, active_slot
//   APB       in         psel / penable  slot_ticks, min_pulse_us, max_pulse_us
//
// One request per clock is taken while the result side keeps up; its result
// passes through the input register, then the result register holding the
// new state. The counter, compare and clamp logic between them is combinational.
// Synchronous active-low reset; the widths reset to 3000 ticks, slot to last.
// A stalled result holds in the result register; the input register fills
// behind it and input ready drops only when both registers are occupied.
// ----------------------------------------------------------------------------
module servo_pwm_slot_multiplexer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    spsm_req_if.sink                      i_req,
    spsm_rsp_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spsm_pkg::ADDR_W-1:0]   paddr,
    input  logic [spsm_pkg::DATA_W-1:0]   pwdata,
    output logic [spsm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int SLOT_COUNT  = spsm_pkg::SLOT_COUNT;
    localparam int GROUP_COUNT = spsm_pkg::GROUP_COUNT;
    localparam int SW     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PW     = GROUP_COUNT * SLOT_COUNT;
    localparam int CNT_W  = spsm_pkg::CNT_W;
    localparam int TICK_W = spsm_pkg::TICK_W;
    localparam int US_W   = spsm_pkg::US_W;
    localparam int CH_W   = spsm_pkg::CH_W;
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

    typedef logic [TICK_W-1:0] t_width_row [SLOT_COUNT];

    // Configuration registers
    logic [CNT_W-1:0] r_slot_ticks;
    logic [US_W-1:0]  r_min_us;
    logic [US_W-1:0]  r_max_us;

    // Input register
    logic                   r_in_vld;
    spsm_pkg::t_req         r_in;

    // Block state
    logic [CNT_W-1:0]                          r_count,  n_count;
    logic [SW-1:0]                             r_slot,   n_slot;
    logic [GROUP_COUNT-1:0][SLOT_COUNT-1:0]    r_pins,   n_pins;
    logic [TICK_W-1:0]                         r_latch [GROUP_COUNT];
    logic [TICK_W-1:0]                         n_latch [GROUP_COUNT];
    t_width_row                                r_widths [GROUP_COUNT];
    t_width_row                                n_widths [GROUP_COUNT];

    // Result register
    logic                   r_out_vld;
    spsm_pkg::t_rsp         r_out;

    logic                   proc;
    logic                   cfg_wr;
    logic [1:0]             cfg_idx;
    logic [CNT_W:0]         cnt_inc;
    logic                   wrap;
    logic [SW-1:0]          slot_inc;
    logic [CH_W-1:0]        wr_grp;
    logic [SW-1:0]          wr_slot;
    logic [US_W-1:0]        clamped;
    logic [PW+15:0]         pins_ext;
    logic [SW+2:0]          slot_ext;

    // Handshakes
    assign proc        = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_in_vld || proc;
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.servo_pins  = r_out.servo_pins;
    assign o_rsp.active_slot = r_out.active_slot;

    // APB register access
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (cfg_idx)
            spsm_pkg::REG_SLOT_TICKS: prdata = {16'b0, r_slot_ticks};
            spsm_pkg::REG_MIN_US:     prdata = {20'b0, r_min_us};
            spsm_pkg::REG_MAX_US:     prdata = {20'b0, r_max_us};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_ticks <= spsm_pkg::RST_SLOT_TICKS;
            r_min_us     <= spsm_pkg::RST_MIN_US;
            r_max_us     <= spsm_pkg::RST_MAX_US;
        end else if (cfg_wr) begin
            case (cfg_idx)
                spsm_pkg::REG_SLOT_TICKS: r_slot_ticks <= pwdata[CNT_W-1:0];
                spsm_pkg::REG_MIN_US:     r_min_us     <= pwdata[US_W-1:0];
                spsm_pkg::REG_MAX_US:     r_max_us     <= pwdata[US_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in.op       <= i_req.op;
            r_in.channel  <= i_req.channel;
            r_in.width_us <= i_req.width_us;
        end
    end

    // Counter, slot advance and write decode
    assign cnt_inc  = {1'b0, r_count} + {{CNT_W{1'b0}}, 1'b1};
    assign wrap     = cnt_inc >= {1'b0, r_slot_ticks};
    assign slot_inc = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
    assign wr_grp   = CH_W'(r_in.channel / SLOT_COUNT);
    assign wr_slot  = SW'(r_in.channel % SLOT_COUNT);

    // Clamp to the limits, low limit first
    always_comb begin
        if (r_in.width_us < r_min_us) begin
            clamped = r_min_us;
        end else if (r_in.width_us > r_max_us) begin
            clamped = r_max_us;
        end else begin
            clamped = r_in.width_us;
        end
    end

    // Next state for one request
    always_comb begin
        n_count  = r_count;
        n_slot   = r_slot;
        n_pins   = r_pins;
        n_latch  = r_latch;
        n_widths = r_widths;
        if (proc) begin
            if (r_in.op == spsm_pkg::OP_TICK) begin
                // wrap: raise and latch the new slot before the compare
                if (wrap) begin
                    n_count = '0;
                    n_slot  = slot_inc;
                    for (int g = 0; g < GROUP_COUNT; g++) begin
                        n_pins[g][slot_inc] = 1'b1;
                        n_latch[g]          = r_widths[g][slot_inc];
                    end
                end else begin
                    n_count = cnt_inc[CNT_W-1:0];
                end
                // drop each group's pin when the count meets its width
                for (int g = 0; g < GROUP_COUNT; g++) begin
                    if (n_count == {{(CNT_W-TICK_W){1'b0}}, n_latch[g]}) begin
                        n_pins[g][n_slot] = 1'b0;
                    end
                end
            end else begin
                // store doubled width; channels beyond the groups drop out
                for (int g = 0; g < GROUP_COUNT; g++) begin
                    if (wr_grp == CH_W'(g)) begin
                        n_widths[g][wr_slot] = {clamped, 1'b0};
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_slot  <= LAST_SLOT;
            r_pins  <= '0;
            for (int g = 0; g < GROUP_COUNT; g++) begin
                r_latch[g] <= spsm_pkg::RST_WIDTH;
                for (int s = 0; s < SLOT_COUNT; s++) begin
                    r_widths[g][s] <= spsm_pkg::RST_WIDTH;
                end
            end
        end else begin
            r_count  <= n_count;
            r_slot   <= n_slot;
            r_pins   <= n_pins;
            r_latch  <= n_latch;
            r_widths <= n_widths;
        end
    end

    // Fit pins and slot to the result field widths
    assign pins_ext = {16'b0, n_pins};
    assign slot_ext = {3'b0, n_slot};

    // Result register: load on process, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (proc) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out.servo_pins  <= pins_ext[15:0];
            r_out.active_slot <= slot_ext[2:0];
        end
    end

endmodule

// ----- tb/sv/servo_pulse_checker.sv -----
// ----------------------------------------------------------------------------
// servo_pulse_checker: pin level predictor and result checker
// Watches the request, result and APB channels of the servo slot multiplexer,
// keeps its own copy of the counter, slot, width stores and pin levels, and
// compares every result against the oldest predicted pin levels.
// ----------------------------------------------------------------------------
module servo_pulse_checker
    import spsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    spsm_req_if               req_ch,
    spsm_rsp_if               rsp_ch,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    output int                o_mismatches,
    output int                o_pending,
    output int                o_checked
);

    localparam int SLOT_N  = 8;
    localparam int GROUP_N = 2;

    // Register copies
    logic [CNT_W-1:0]  slot_len;
    logic [US_W-1:0]   min_us;
    logic [US_W-1:0]   max_us;

    // Timing and pin state
    logic [CNT_W-1:0]  count;
    logic [SLOT_W-1:0] slot;
    logic [TICK_W-1:0] stored_width [GROUP_N][SLOT_N];
    logic [TICK_W-1:0] held_width [GROUP_N];
    logic [PINS_W-1:0] pins;

    t_rsp expected_levels [$];
    int   mismatch_total;
    int   checked_total;

    task automatic reset_servo_model();
        slot_len = RST_SLOT_TICKS;
        min_us   = RST_MIN_US;
        max_us   = RST_MAX_US;
        count    = '0;
        slot     = SLOT_W'(SLOT_N - 1);
        pins     = '0;
        for (int g = 0; g < GROUP_N; g++) begin
            held_width[g] = RST_WIDTH;
            for (int s = 0; s < SLOT_N; s++) begin
                stored_width[g][s] = RST_WIDTH;
            end
        end
    endtask

    // Apply one request to the model and return the pin levels after it
    task automatic compute_pin_levels(input t_req r, output t_rsp res);
        logic [CNT_W:0]  next;
        logic [US_W-1:0] w;
        if (r.op == OP_TICK) begin
            next = {1'b0, count} + 1'b1;
            // Wrap at or past the slot length: raise and latch the new slot
            if (next >= {1'b0, slot_len}) begin
                count = '0;
                slot  = slot + 1'b1;
                for (int g = 0; g < GROUP_N; g++) begin
                    pins[g * SLOT_N + int'(slot)] = 1'b1;
                    held_width[g] = stored_width[g][slot];
                end
            end else begin
                count = next[CNT_W-1:0];
            end
            // Drop after the wrap, on the new count
            for (int g = 0; g < GROUP_N; g++) begin
                if (count == CNT_W'(held_width[g])) begin
                    pins[g * SLOT_N + int'(slot)] = 1'b0;
                end
            end
        end else begin
            // Clamp below min first, then above max (crossed limits: below min gets min, else max)
            w = r.width_us;
            if (w < min_us) begin
                w = min_us;
            end else if (w > max_us) begin
                w = max_us;
            end
            if (int'(r.channel) / SLOT_N < GROUP_N) begin
                stored_width[int'(r.channel) / SLOT_N][int'(r.channel) % SLOT_N] = {w, 1'b0};
            end
        end
        res.servo_pins  = pins;
        res.active_slot = slot;
    endtask

    always @(posedge i_clk) begin : watch
        t_req req;
        t_rsp want;
        if (!i_rst_n) begin
            reset_servo_model();
            expected_levels.delete();
            mismatch_total = 0;
            checked_total  = 0;
        end else begin
            // Compare a delivered result with the oldest prediction
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_levels.size() == 0) begin
                    $error("unexpected result: servo_pins=%h active_slot=%0d",
                           rsp_ch.servo_pins, rsp_ch.active_slot);
                    mismatch_total++;
                end else begin
                    want = expected_levels.pop_front();
                    checked_total++;
                    if (rsp_ch.servo_pins !== want.servo_pins) begin
                        $error("servo_pins mismatch: expected %h, actual %h",
                               want.servo_pins, rsp_ch.servo_pins);
                        mismatch_total++;
                    end
                    if (rsp_ch.active_slot !== want.active_slot) begin
                        $error("active_slot mismatch: expected %0d, actual %0d",
                               want.active_slot, rsp_ch.active_slot);
                        mismatch_total++;
                    end
                end
            end
            // Track register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_SLOT_TICKS: slot_len = i_pwdata[CNT_W-1:0];
                    REG_MIN_US:     min_us   = i_pwdata[US_W-1:0];
                    REG_MAX_US:     max_us   = i_pwdata[US_W-1:0];
                    default: ;
                endcase
            end
            // Predict the result of an accepted request
            if (req_ch.valid && req_ch.ready) begin
                req.op       = req_ch.op;
                req.channel  = req_ch.channel;
                req.width_us = req_ch.width_us;
                compute_pin_levels(req, want);
                expected_levels.push_back(want);
            end
        end
        o_mismatches <= mismatch_total;
        o_pending    <= expected_levels.size();
        o_checked    <= checked_total;
    end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: servo slot multiplexer stimulus and verdict
// Drives directed and random tick and width requests through a series of
// register settings, idles both channels at random, holds the result side
// off once for a long stretch, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
    import spsm_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 4;
    localparam int RANDOM_PHASE = 10;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int mismatches;
    int pending;
    int checked;

    int n_requests;
    int n_ticks;
    int n_writes;
    int n_settings;
    int burst_left;
    bit long_hold_done;

    logic [US_W-1:0] cur_min;
    logic [US_W-1:0] cur_max;

    spsm_req_if req_ch ();
    spsm_rsp_if rsp_ch ();

    servo_pwm_slot_multiplexer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    servo_pulse_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req_ch       (req_ch),
        .rsp_ch       (rsp_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Setup then access cycle; the register is written at the access edge
    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic configure(input logic [CNT_W-1:0] len, input logic [US_W-1:0] lo,
                             input logic [US_W-1:0] hi);
        write_reg(REG_SLOT_TICKS, DATA_W'(len));
        write_reg(REG_MIN_US, DATA_W'(lo));
        write_reg(REG_MAX_US, DATA_W'(hi));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        cur_min = lo;
        cur_max = hi;
        n_settings++;
    endtask

    // Offer one request after a random gap and hold it until taken
    task automatic send_request(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                                input logic [US_W-1:0] w);
        int gap;
        int r;
        gap = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            r = $urandom_range(0, 19);
            if (r >= 18) begin
                gap = $urandom_range(10, 40);
            end else if (r >= 12) begin
                gap = $urandom_range(1, 3);
            end
            if ($urandom_range(0, 29) == 0) begin
                burst_left = $urandom_range(30, 80);
            end
        end
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.op       <= op;
        req_ch.channel  <= ch;
        req_ch.width_us <= w;
        do @(posedge i_clk); while (!req_ch.ready);
        n_requests++;
        if (op == OP_TICK) begin
            n_ticks++;
        end else begin
            n_writes++;
        end
    endtask

    // Mostly ticks; widths either anywhere or up to just past the higher limit
    task automatic send_random_request();
        logic [OP_W-1:0] op;
        logic [US_W-1:0] w;
        int              top;
        op  = ($urandom_range(0, 9) < 7) ? OP_TICK : OP_WRITE;
        top = ((cur_max > cur_min) ? int'(cur_max) : int'(cur_min)) + 3;
        if (top > 4095) begin
            top = 4095;
        end
        if ($urandom_range(0, 9) < 4) begin
            w = US_W'($urandom_range(0, 4095));
        end else begin
            w = US_W'($urandom_range(0, top));
        end
        send_request(op, CH_W'($urandom_range(0, 15)), w);
    endtask

    // Drop valid and wait for every predicted result, then let the pipe settle
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Result side: random ready with stretches, plus one long hold-off
    initial begin
        int r;
        int hold;
        rsp_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!long_hold_done && n_requests >= 560) begin
                rsp_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                long_hold_done = 1'b1;
            end else begin
                r = $urandom_range(0, 19);
                if (r < 10) begin
                    rsp_ch.ready <= 1'b1;
                    hold = $urandom_range(1, 20);
                end else if (r < 12) begin
                    rsp_ch.ready <= 1'b1;
                    hold = $urandom_range(100, 200);
                end else if (r < 18) begin
                    rsp_ch.ready <= 1'b0;
                    hold = $urandom_range(1, 3);
                end else begin
                    rsp_ch.ready <= 1'b0;
                    hold = $urandom_range(10, 40);
                end
                // cut the stretch short so the long hold-off starts mid-traffic
                repeat (hold) begin
                    @(posedge i_clk);
                    if (!long_hold_done && n_requests >= 560) begin
                        break;
                    end
                end
            end
        end
    end

    // Give up if the run hangs
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    initial begin
        int               n_items;
        logic [CNT_W-1:0] len;
        logic [US_W-1:0]  lo;
        logic [US_W-1:0]  hi;
        n_requests      = 0;
        n_ticks         = 0;
        n_writes        = 0;
        n_settings      = 0;
        burst_left      = 0;
        long_hold_done  = 1'b0;
        cur_min         = RST_MIN_US;
        cur_max         = RST_MAX_US;
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        req_ch.valid    <= 1'b0;
        req_ch.op       <= OP_TICK;
        req_ch.channel  <= '0;
        req_ch.width_us <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset limits: clamp both field extremes, touch both groups' ends
        send_request(OP_WRITE, 4'd0, 12'd0);
        send_request(OP_WRITE, 4'd15, 12'd4095);
        send_request(OP_WRITE, 4'd7, 12'd900);
        send_request(OP_WRITE, 4'd8, 12'd2100);
        send_request(OP_TICK, 4'd0, 12'd0);
        send_request(OP_TICK, 4'd15, 12'd4095);
        wait_for_results();

        // Zero slot length wraps on every tick; zero width gives no pulse
        configure(16'd0, 12'd0, 12'd4095);
        repeat (3) send_request(OP_TICK, 4'd0, 12'd0);
        send_request(OP_WRITE, 4'd1, 12'd0);
        send_request(OP_WRITE, 4'd9, 12'd0);
        repeat (3) send_request(OP_TICK, 4'd0, 12'd0);
        wait_for_results();

        // Crossed limits; widths past the slot length never drop in their slot
        configure(16'd4, 12'd3000, 12'd100);
        send_request(OP_WRITE, 4'd2, 12'd50);
        send_request(OP_WRITE, 4'd3, 12'd4000);
        send_request(OP_WRITE, 4'd10, 12'd2000);
        repeat (6) send_request(OP_TICK, 4'd0, 12'd0);
        wait_for_results();

        // Random phases over a spread of settings, extremes first
        for (int p = 0; p < RANDOM_PHASE; p++) begin
            n_items = 130;
            case (p)
                0: begin
                    len = 16'd1;     lo = 12'd0;    hi = 12'd4095;
                end
                1: begin
                    len = 16'd65535; lo = 12'd4095; hi = 12'd4095;
                    n_items = 60;
                end
                2: begin
                    len = 16'd300;   lo = 12'd50;   hi = 12'd200;
                    n_items = 250;
                end
                default: begin
                    len = CNT_W'($urandom_range(2, 40));
                    lo  = US_W'($urandom_range(0, 10));
                    hi  = US_W'($urandom_range(0, 25));
                end
            endcase
            configure(len, lo, hi);
            repeat (n_items) send_random_request();
            wait_for_results();
        end

        repeat (8) @(posedge i_clk);
        $display("Sent %0d requests (%0d ticks, %0d width writes) over %0d settings",
                 n_requests, n_ticks, n_writes, n_settings);
        $display("Checked %0d results, long result stall %0s",
                 checked, long_hold_done ? "applied" : "not reached");
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
